// ===== hdl/srf_pkg.sv =====
// Shared types and constants for the segmented ring FIFO.
// No dependencies; every other file in hdl/ imports this package.
package srf_pkg;

   // Pool and row geometry.
   localparam int MAX_BLOCKS = 16;
   localparam int BLOCK_ROWS = 256;
   localparam int ROW_BITS   = 64;
   localparam int STAMP_BITS = 48;

   localparam int SLOT_W   = $clog2(MAX_BLOCKS);
   localparam int IDX_W    = $clog2(BLOCK_ROWS);
   localparam int ADDR_W   = SLOT_W + IDX_W;
   localparam int RPB_W    = 9;
   localparam int BLK_W    = 5;
   localparam int CNT_W    = 12;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [RPB_W-1:0] RPB_RESET = RPB_W'(BLOCK_ROWS);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PURGE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Row store write request.
   typedef struct packed {
      logic                  we;
      logic [ADDR_W-1:0]     addr;
      logic [ROW_BITS-1:0]   payload;
      logic [STAMP_BITS-1:0] stamp;
   } wr_req_type;

   // Per-request result information from the block controller.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_empty;
      logic [CNT_W-1:0]    row_count;
      logic [BLK_W-1:0]    blocks;
      logic                fwd;
   } rsp_info_type;

endpackage

// ===== hdl/srf_row_ram.sv =====
// Row store of the segmented ring FIFO: payload and timestamp arrays.
// One write port and one registered read port. Depends on srf_pkg.
module srf_row_ram import srf_pkg::*; (
   input  logic                  clock,
   input  wr_req_type            wr,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [ROW_BITS-1:0]   rd_payload,
   output logic [STAMP_BITS-1:0] rd_stamp
);

   logic [ROW_BITS-1:0]   payload_mem [MAX_BLOCKS*BLOCK_ROWS];
   logic [STAMP_BITS-1:0] stamp_mem   [MAX_BLOCKS*BLOCK_ROWS];
   logic [ROW_BITS-1:0]   rd_payload_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         payload_mem[wr.addr] <= wr.payload;
         stamp_mem[wr.addr]   <= wr.stamp;
      end
   end

   // Registered read port; a same-cycle write is forwarded by the caller.
   always_ff @(posedge clock) begin
      rd_payload_ff <= payload_mem[rd_addr];
      rd_stamp_ff   <= stamp_mem[rd_addr];
   end

   assign rd_payload = rd_payload_ff;
   assign rd_stamp   = rd_stamp_ff;

endmodule

// ===== hdl/srf_ctrl.sv =====
// Block controller of the segmented ring FIFO: block table, head slot, counts
// and the ring length register. Depends on srf_pkg.
module srf_ctrl import srf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [FUNC_W-1:0]     item_func,
   input  logic [ROW_BITS-1:0]   item_payload,
   input  logic [STAMP_BITS-1:0] item_stamp,
   input  logic                  csr_we,
   input  logic [RPB_W-1:0]      csr_wdata,
   output wr_req_type            wr,
   output logic [ADDR_W-1:0]     rd_addr,
   output rsp_info_type          info
);

   // Advance a ring index by one, wrapping at the ring length.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [RPB_W-1:0] len);
      logic [RPB_W-1:0] inc;
      inc = RPB_W'(idx) + RPB_W'(1);
      return (inc == len) ? '0 : inc[IDX_W-1:0];
   endfunction

   // Hold the ring length inside its legal range.
   function automatic logic [RPB_W-1:0] clamp_len(input logic [RPB_W-1:0] v);
      logic [RPB_W-1:0] r;
      r = v;
      if (v < RPB_W'(2)) r = RPB_W'(2);
      if (v > RPB_RESET) r = RPB_RESET;
      return r;
   endfunction

   logic [RPB_W-1:0]  rpb_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [BLK_W-1:0]  blk_cnt_ff, blk_cnt_in;
   logic [CNT_W-1:0]  elem_cnt_ff, elem_cnt_in;
   logic [IDX_W-1:0]  start_ff [MAX_BLOCKS];
   logic [IDX_W-1:0]  start_in [MAX_BLOCKS];
   logic [IDX_W-1:0]  end_ff   [MAX_BLOCKS];
   logic [IDX_W-1:0]  end_in   [MAX_BLOCKS];

   logic                no_blk;
   logic [SLOT_W-1:0]   tail_slot, push_slot, new_slot, head_next;
   logic [IDX_W-1:0]    push_start, push_end, push_next, push_next2;
   logic                push_full;
   logic [BLK_W-1:0]    blk_after;
   logic [IDX_W-1:0]    pop_start, head_start;
   logic                pop_drain;
   logic [STATUS_W-1:0] status;

   // Tail and push geometry; with no block the head slot is taken fresh.
   assign no_blk     = (blk_cnt_ff == '0);
   assign tail_slot  = head_ff + blk_cnt_ff[SLOT_W-1:0] - SLOT_W'(1);
   assign push_slot  = no_blk ? head_ff : tail_slot;
   assign push_start = no_blk ? '0 : start_ff[push_slot];
   assign push_end   = no_blk ? '0 : end_ff[push_slot];
   assign push_next  = next_idx(push_end, rpb_ff);
   assign push_next2 = next_idx(push_next, rpb_ff);
   assign push_full  = (push_next == push_start);
   assign blk_after  = no_blk ? BLK_W'(1) : blk_cnt_ff;
   assign new_slot   = head_ff + blk_after[SLOT_W-1:0];

   // Pop geometry: the head block drains when its start meets its end and it is not the last block.
   assign head_next = head_ff + SLOT_W'(1);
   assign pop_start = next_idx(start_ff[head_ff], rpb_ff);
   assign pop_drain = (blk_cnt_ff > BLK_W'(1)) && (pop_start == end_ff[head_ff]);

   // Next state for one request.
   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      head_in     = head_ff;
      blk_cnt_in  = blk_cnt_ff;
      elem_cnt_in = elem_cnt_ff;
      status      = ST_DONE;
      head_start  = start_ff[head_ff];
      wr.we       = 1'b0;
      wr.addr     = {push_slot, push_end};
      wr.payload  = item_payload;
      wr.stamp    = item_stamp;
      case (item_func)
         FUNC_PUSH: begin
            if (push_full) begin
               status = ST_FULL;
            end else begin
               wr.we = item_valid;
               if (no_blk) begin
                  start_in[push_slot] = '0;
                  head_start          = '0;
               end
               end_in[push_slot] = push_next;
               elem_cnt_in       = elem_cnt_ff + CNT_W'(1);
               blk_cnt_in        = blk_after;
               // Take a fresh block as soon as the tail has no free slot and the pool has one left.
               if (push_next2 == push_start && blk_after < BLK_W'(MAX_BLOCKS)) begin
                  start_in[new_slot] = '0;
                  end_in[new_slot]   = '0;
                  blk_cnt_in         = blk_after + BLK_W'(1);
               end
            end
         end
         FUNC_POP: begin
            if (elem_cnt_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               start_in[head_ff] = pop_start;
               elem_cnt_in       = elem_cnt_ff - CNT_W'(1);
               head_start        = pop_start;
               if (pop_drain) begin
                  head_in    = head_next;
                  blk_cnt_in = blk_cnt_ff - BLK_W'(1);
                  head_start = start_ff[head_next];
               end
            end
         end
         FUNC_PURGE: begin
            if (!no_blk) begin
               head_in             = tail_slot;
               blk_cnt_in          = BLK_W'(1);
               start_in[tail_slot] = end_ff[tail_slot];
               elem_cnt_in         = '0;
               head_start          = end_ff[tail_slot];
            end
         end
         FUNC_CLEAR: begin
            start_in    = '{default: '0};
            end_in      = '{default: '0};
            head_in     = '0;
            blk_cnt_in  = '0;
            elem_cnt_in = '0;
            head_start  = '0;
         end
         FUNC_PEEK: begin
         end
         default: begin
         end
      endcase
   end

   // Head row address after the request; forward when it is written now.
   assign rd_addr        = {head_in, head_start};
   assign info.status    = status;
   assign info.is_empty  = (elem_cnt_in == '0);
   assign info.row_count = elem_cnt_in;
   assign info.blocks    = blk_cnt_in;
   assign info.fwd       = wr.we && (wr.addr == rd_addr);

   // State registers; a register write empties the queue like a clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         rpb_ff      <= RPB_RESET;
         start_ff    <= '{default: '0};
         end_ff      <= '{default: '0};
         head_ff     <= '0;
         blk_cnt_ff  <= '0;
         elem_cnt_ff <= '0;
      end else if (csr_we) begin
         rpb_ff      <= clamp_len(csr_wdata);
         start_ff    <= '{default: '0};
         end_ff      <= '{default: '0};
         head_ff     <= '0;
         blk_cnt_ff  <= '0;
         elem_cnt_ff <= '0;
      end else if (item_valid) begin
         start_ff    <= start_in;
         end_ff      <= end_in;
         head_ff     <= head_in;
         blk_cnt_ff  <= blk_cnt_in;
         elem_cnt_ff <= elem_cnt_in;
      end
   end

`ifndef SYNTHESIS
   // The pool never hands out more blocks than it has.
   assert property (@(posedge clock) disable iff (reset)
      blk_cnt_ff <= BLK_W'(MAX_BLOCKS))
      else $error("block count above pool size");

   // Held rows always live in some block.
   assert property (@(posedge clock) disable iff (reset)
      (elem_cnt_ff != '0) |-> (blk_cnt_ff != '0))
      else $error("rows held with no block taken");

   // A push can be refused only by a tail block that already exists.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_func == FUNC_PUSH && push_full) |-> !no_blk)
      else $error("push refused with no block taken");

   // The ring length stays within its clamped range.
   assert property (@(posedge clock) disable iff (reset)
      (rpb_ff >= RPB_W'(2)) && (rpb_ff <= RPB_RESET))
      else $error("ring length out of range");
`endif

endmodule

// ===== hdl/segmented_ring_fifo.sv =====
// Top level of the segmented ring FIFO: request register, block controller,
// row store and result register. Depends on srf_pkg, srf_ctrl, srf_row_ram.
//
//   Channel   Handshake              Payload
//   request   start, busy            req_func, req_payload, req_timestamp
//   result    rsp_valid (strobe)     rsp_status, rsp_is_empty, rsp_head_payload,
//                                    rsp_head_timestamp, rsp_row_count,
//                                    rsp_blocks_in_use
//   config    csr_valid, csr_ready   csr_wdata (rows per block)
//
// One request is accepted every cycle; busy is always low.
// An accepted request waits in the request register, then updates the block
// table as its result and the row store's read load their registers; the
// result strobes for one cycle. Reset is synchronous and empties the queue;
// the row store needs no clearing. The receiver cannot stall results. A
// configuration write waits while a request sits in the request register.
module segmented_ring_fifo import srf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [ROW_BITS-1:0]   req_payload,
   input  logic [STAMP_BITS-1:0] req_timestamp,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_is_empty,
   output logic [ROW_BITS-1:0]   rsp_head_payload,
   output logic [STAMP_BITS-1:0] rsp_head_timestamp,
   output logic [CNT_W-1:0]      rsp_row_count,
   output logic [BLK_W-1:0]      rsp_blocks_in_use,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RPB_W-1:0]      csr_wdata
);

   logic                  req_valid_ff;
   logic [FUNC_W-1:0]     func_ff;
   logic [ROW_BITS-1:0]   payload_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  rsp_valid_ff;
   rsp_info_type          info_ff;
   logic [ROW_BITS-1:0]   fwd_payload_ff;
   logic [STAMP_BITS-1:0] fwd_stamp_ff;

   logic                  accept;
   logic                  csr_we;
   wr_req_type            wr;
   logic [ADDR_W-1:0]     rd_addr;
   rsp_info_type          info;
   logic [ROW_BITS-1:0]   ram_payload;
   logic [STAMP_BITS-1:0] ram_stamp;

   // Request and configuration handshakes.
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign csr_ready = !req_valid_ff;
   assign csr_we    = csr_valid && csr_ready;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= req_func;
      payload_ff <= req_payload;
      stamp_ff   <= req_timestamp;
   end

   srf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_valid_ff),
      .item_func    (func_ff),
      .item_payload (payload_ff),
      .item_stamp   (stamp_ff),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .wr           (wr),
      .rd_addr      (rd_addr),
      .info         (info)
   );

   srf_row_ram u_row_ram (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (rd_addr),
      .rd_payload (ram_payload),
      .rd_stamp   (ram_stamp)
   );

   // Result register, alongside the row store's read register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      info_ff        <= info;
      fwd_payload_ff <= wr.payload;
      fwd_stamp_ff   <= wr.stamp;
   end

   // Head row: zero when empty, the just-written row when it became the head.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = info_ff.status;
   assign rsp_is_empty       = info_ff.is_empty;
   assign rsp_row_count      = info_ff.row_count;
   assign rsp_blocks_in_use  = info_ff.blocks;
   assign rsp_head_payload   = info_ff.is_empty ? '0 :
                               (info_ff.fwd ? fwd_payload_ff : ram_payload);
   assign rsp_head_timestamp = info_ff.is_empty ? '0 :
                               (info_ff.fwd ? fwd_stamp_ff : ram_stamp);

`ifndef SYNTHESIS
   // Every accepted request yields exactly one result, through the request and result registers.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted request produced no result");

   // An empty result reports no rows.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_row_count == '0))
      else $error("empty result with nonzero row count");

   // A forwarded head row comes only from a push.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && info_ff.fwd) |-> (rsp_status == ST_DONE && !rsp_is_empty))
      else $error("row forwarded without a completed push");
`endif

endmodule
